### design/bsd_pkg.sv
package bsd_pkg;

	localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
	localparam logic [31:0] MEM_MASK  = 32'hffff_fff0;
	localparam logic [31:0] IO_MASK   = 32'hffff_fffc;
	localparam logic [31:0] ROM_MASK  = 32'hffff_f800;
	localparam logic [31:0] IO_LIMIT  = 32'h0000_ffff;
	localparam logic [2:0]  MEM_TYPE_64 = 3'b100;

	typedef enum logic {
		OP_BAR = 1'b0,
		OP_ROM = 1'b1
	} op_t;

	typedef struct packed {
		logic       valid_res;
		logic       space_io;
		logic       prefetchable;
		logic       wide_bar;
		logic       read_only_rom;
		logic       rom_enabled;
		logic [3:0] type_bits;
		logic       uses_next_slot;
	} flags_t;

endpackage

### design/bsd_in_if.sv
interface bsd_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] original_low;
	logic [31:0] sizing_low;
	logic [31:0] original_high;
	logic [31:0] sizing_high;

	modport source(output valid, output opcode, output original_low, output sizing_low,
		output original_high, output sizing_high, input ready);
	modport sink(input valid, input opcode, input original_low, input sizing_low,
		input original_high, input sizing_high, output ready);
endinterface

### design/bsd_out_if.sv
interface bsd_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic        space_io;
	logic        prefetchable;
	logic        wide_bar;
	logic        read_only_rom;
	logic        rom_enabled;
	logic [3:0]  type_bits;
	logic [63:0] start_address;
	logic [63:0] end_address;
	logic        uses_next_slot;

	modport source(output valid, output valid_res, output space_io, output prefetchable,
		output wide_bar, output read_only_rom, output rom_enabled, output type_bits,
		output start_address, output end_address, output uses_next_slot, input ready);
	modport sink(input valid, input valid_res, input space_io, input prefetchable,
		input wide_bar, input read_only_rom, input rom_enabled, input type_bits,
		input start_address, input end_address, input uses_next_slot, output ready);
endinterface

### design/bsd_decode.sv
module bsd_decode import bsd_pkg::*; (
	input  logic        opcode,
	input  logic [31:0] original_low,
	input  logic [31:0] sizing_low,
	input  logic [31:0] original_high,
	input  logic [31:0] sizing_high,
	input  logic        wide_en,
	output flags_t      flags,
	output logic [63:0] start,
	output logic [63:0] size
);

	logic [31:0] orig;
	logic [31:0] masked;
	logic        size_ok;

	always_comb begin
		orig    = (original_low == ALL_ONES) ? '0 : original_low;
		masked  = sizing_low & MEM_MASK;
		size_ok = (sizing_low != '0) && (sizing_low != ALL_ONES);
		flags   = '0;
		start   = '0;
		size    = '0;
		if (size_ok) begin
			if (op_t'(opcode) == OP_ROM) begin
				flags.valid_res     = 1'b1;
				flags.prefetchable  = 1'b1;
				flags.read_only_rom = 1'b1;
				flags.rom_enabled   = orig[0];
				start = {32'd0, orig & ROM_MASK};
				size  = {32'd0, ~(sizing_low & ROM_MASK)};
			end else if (orig[0]) begin
				flags.valid_res = 1'b1;
				flags.space_io  = 1'b1;
				flags.type_bits = orig[3:0];
				start = {32'd0, orig & IO_MASK};
				size  = {32'd0, ~(sizing_low & IO_MASK) & IO_LIMIT};
			end else begin
				flags.valid_res    = 1'b1;
				flags.type_bits    = orig[3:0];
				flags.prefetchable = orig[3];
				start = {32'd0, orig & MEM_MASK};
				size  = {32'd0, ~masked};
				if (orig[2:0] == MEM_TYPE_64) begin
					flags.wide_bar       = 1'b1;
					flags.uses_next_slot = 1'b1;
					if (wide_en) begin
						start[63:32] = original_high;
						if (sizing_high != '0)
							size = ~{sizing_high, masked};
					end else if (original_high != '0) begin
						// upper dword set but no 64-bit support: slot still taken
						flags = '0;
						flags.uses_next_slot = 1'b1;
						start = '0;
						size  = '0;
					end
				end
			end
		end
	end

endmodule

### design/bar_sizing_decoder_unit.sv
// BAR sizing decoder.
// in_ch carries one register to decode: opcode (normal BAR or expansion ROM),
// the original low/high dwords and their all-ones sizing readbacks. out_ch
// returns one result per transfer: flags, start address and end address.
// cfg_we/cfg_wdata write the 64-bit support enable; write only while idle.
// Pipeline: s1 decodes and registers start and size, s2 adds the low 32 bits
// and keeps the carry, s3 adds the upper 32 bits and is the output register.
// An input transfer is registered in s1, s2 and s3 before out_ch.valid; throughput is
// one item per cycle through the three stages while out_ch.ready stays high.
// Reset clears all stage valid bits and sets 64-bit support on.
// When out_ch.ready is low, the s3 result holds and earlier stages keep
// filling any empty slot, so up to two more items are taken before
// in_ch.ready drops; nothing is lost or repeated.
module bar_sizing_decoder_unit import bsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	bsd_in_if.sink      in_ch,
	bsd_out_if.source   out_ch
);

	logic        wide_en_q;
	flags_t      dec_flags;
	logic [63:0] dec_start;
	logic [63:0] dec_size;

	logic        v_s1, v_s2, v_s3;
	logic        en1, en2, en3;
	flags_t      flags_s1, flags_s2, flags_s3;
	logic [63:0] start_s1;
	logic [63:0] size_s1;
	logic [63:0] start_s2;
	logic [31:0] size_hi_s2;
	logic [31:0] end_lo_s2;
	logic        carry_s2;
	logic [63:0] start_s3;
	logic [63:0] end_s3;
	logic [32:0] sum_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wide_en_q <= 1'b1;
		else if (cfg_we)
			wide_en_q <= cfg_wdata;
	end

	bsd_decode u_decode (
		.opcode        (in_ch.opcode),
		.original_low  (in_ch.original_low),
		.sizing_low    (in_ch.sizing_low),
		.original_high (in_ch.original_high),
		.sizing_high   (in_ch.sizing_high),
		.wide_en       (wide_en_q),
		.flags         (dec_flags),
		.start         (dec_start),
		.size          (dec_size)
	);

	assign en3 = !v_s3 || out_ch.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	assign sum_lo = {1'b0, start_s1[31:0]} + {1'b0, size_s1[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_ch.valid) begin
			flags_s1 <= dec_flags;
			start_s1 <= dec_start;
			size_s1  <= dec_size;
		end
		if (en2 && v_s1) begin
			flags_s2   <= flags_s1;
			start_s2   <= start_s1;
			size_hi_s2 <= size_s1[63:32];
			end_lo_s2  <= sum_lo[31:0];
			carry_s2   <= sum_lo[32];
		end
		if (en3 && v_s2) begin
			flags_s3 <= flags_s2;
			start_s3 <= start_s2;
			end_s3   <= {start_s2[63:32] + size_hi_s2 + {31'd0, carry_s2}, end_lo_s2};
		end
	end

	assign out_ch.valid          = v_s3;
	assign out_ch.valid_res      = flags_s3.valid_res;
	assign out_ch.space_io       = flags_s3.space_io;
	assign out_ch.prefetchable   = flags_s3.prefetchable;
	assign out_ch.wide_bar       = flags_s3.wide_bar;
	assign out_ch.read_only_rom  = flags_s3.read_only_rom;
	assign out_ch.rom_enabled    = flags_s3.rom_enabled;
	assign out_ch.type_bits      = flags_s3.type_bits;
	assign out_ch.uses_next_slot = flags_s3.uses_next_slot;
	assign out_ch.start_address  = start_s3;
	assign out_ch.end_address    = end_s3;

endmodule

### design/bsd_checker.sv
module bsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        valid_res,
	input logic        space_io,
	input logic        wide_bar,
	input logic        read_only_rom,
	input logic [3:0]  type_bits,
	input logic        uses_next_slot,
	input logic [63:0] start_address,
	input logic [63:0] end_address
);

	logic [63:0] span;

	assign span = end_address - start_address;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> start_address == '0 && end_address == '0)
		else $error("invalid result carries an address");

	a_rom_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_only_rom |->
			valid_res && !space_io && !wide_bar && type_bits == '0 && !uses_next_slot)
		else $error("ROM result with BAR flags");

	a_wide_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wide_bar |-> uses_next_slot && valid_res)
		else $error("64-bit BAR without next slot");

	a_io_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && space_io |-> span <= 64'h0000_0000_0000_ffff)
		else $error("I/O span exceeds 16 bits");

endmodule

bind bar_sizing_decoder_unit bsd_checker u_bsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.valid_res      (out_ch.valid_res),
	.space_io       (out_ch.space_io),
	.wide_bar       (out_ch.wide_bar),
	.read_only_rom  (out_ch.read_only_rom),
	.type_bits      (out_ch.type_bits),
	.uses_next_slot (out_ch.uses_next_slot),
	.start_address  (out_ch.start_address),
	.end_address    (out_ch.end_address)
);

### dv/bar_sizing_decoder_unit_tb.sv
module bar_sizing_decoder_unit_tb import bsd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned MAX_WAIT    = 12;
	localparam int unsigned PRINT_LIMIT = 25;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] original_low;
		logic [31:0] sizing_low;
		logic [31:0] original_high;
		logic [31:0] sizing_high;
	} bar_req_t;

	typedef struct packed {
		logic        valid_res;
		logic        space_io;
		logic        prefetchable;
		logic        wide_bar;
		logic        read_only_rom;
		logic        rom_enabled;
		logic [3:0]  type_bits;
		logic [63:0] start_address;
		logic [63:0] end_address;
		logic        uses_next_slot;
	} bar_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	bsd_in_if  in_ch();
	bsd_out_if out_ch();

	bar_sizing_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	bar_req_t bars_to_send[$];
	bar_res_t predicted_decodes[$];
	bar_req_t sent_bar;
	bit wide_support = 1'b1;
	int unsigned settings_used = 1;

	int unsigned mismatches = 0;
	int unsigned decodes_seen = 0;
	int unsigned io_seen = 0;
	int unsigned rom_seen = 0;
	int unsigned wide_seen = 0;
	int unsigned rejected_seen = 0;
	int unsigned quiet_cycles = 0;

	int unsigned send_wait = 0;
	int unsigned send_run = 0;
	bit          send_calm = 1'b0;
	int unsigned recv_wait = 0;
	int unsigned recv_run = 0;
	bit          recv_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected decode of one BAR under the current 64-bit support setting
	function automatic bar_res_t decode_bar(bar_req_t r, bit wide_ok);
		bar_res_t d;
		logic [31:0] base;
		logic [31:0] masked;
		logic [31:0] span;
		d = '0;
		masked = '0;
		base = (r.original_low == ALL_ONES) ? 32'h0 : r.original_low;
		if (r.sizing_low != 32'h0 && r.sizing_low != ALL_ONES) begin
			d.valid_res = 1'b1;
			if (r.opcode == OP_ROM) begin
				span = ~(r.sizing_low & ROM_MASK);
				d.prefetchable = 1'b1;
				d.read_only_rom = 1'b1;
				d.rom_enabled = base[0];
				d.start_address = {32'h0, base & ROM_MASK};
			end else if (base[0]) begin
				span = ~(r.sizing_low & IO_MASK) & IO_LIMIT;
				d.space_io = 1'b1;
				d.type_bits = base[3:0];
				d.start_address = {32'h0, base & IO_MASK};
			end else begin
				masked = r.sizing_low & MEM_MASK;
				span = ~masked;
				d.type_bits = base[3:0];
				d.prefetchable = base[3];
				d.start_address = {32'h0, base & MEM_MASK};
			end
			d.end_address = d.start_address + {32'h0, span};
			if (r.opcode == OP_BAR && base[2:0] == MEM_TYPE_64) begin
				d.wide_bar = 1'b1;
				d.uses_next_slot = 1'b1;
				if (wide_ok) begin
					d.start_address[63:32] = r.original_high;
					d.end_address = d.start_address + ((r.sizing_high != 32'h0) ?
						~{r.sizing_high, masked} : {32'h0, span});
				end else if (r.original_high != 32'h0) begin
					// upper dword not reachable: only the slot claim survives
					d = '0;
					d.uses_next_slot = 1'b1;
				end
			end
		end
		return d;
	endfunction

	function automatic int unsigned pick_wait(bit calm);
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	task automatic queue_bar(op_t op, logic [31:0] ol, logic [31:0] sl,
		logic [31:0] oh, logic [31:0] sh);
		bars_to_send.push_back('{op, ol, sl, oh, sh});
	endtask

	task automatic queue_random(int unsigned count);
		bar_req_t r;
		int unsigned kind;
		int unsigned k;
		logic [31:0] m;
		logic [3:0] tb;
		repeat (count) begin
			r.opcode = OP_BAR;
			r.original_low = $urandom;
			r.sizing_low = $urandom;
			r.original_high = $urandom;
			r.sizing_high = $urandom;
			kind = $urandom_range(0, 99);
			if (kind < 22) begin
				// 32-bit memory, including the reserved type encodings
				k = $urandom_range(4, 31);
				m = ALL_ONES << k;
				tb = 4'($urandom_range(0, 15)) & 4'b1110;
				if (tb[2:1] == 2'b10)
					tb[2] = 1'b0;
				r.original_low = ($urandom & m) | {28'h0, tb};
				r.sizing_low = m | {28'h0, tb};
			end else if (kind < 44) begin
				k = $urandom_range(4, 31);
				m = ALL_ONES << k;
				tb = {1'($urandom_range(0, 1)), 3'b100};
				r.original_low = ($urandom & m) | {28'h0, tb};
				r.sizing_low = m | {28'h0, tb};
				case ($urandom_range(0, 3))
					0: begin
						r.sizing_high = ALL_ONES;
						r.original_high = 32'h0;
					end
					1: begin
						r.sizing_high = ALL_ONES;
					end
					2: begin
						// region of 4 GB or more
						k = $urandom_range(0, 31);
						r.sizing_high = ALL_ONES << k;
						r.sizing_low = {28'h0, tb};
						r.original_low = {28'h0, tb};
						r.original_high = $urandom & (ALL_ONES << k);
					end
					default: begin
						r.sizing_high = 32'h0;
						if ($urandom_range(0, 1) != 0)
							r.original_high = 32'h0;
					end
				endcase
			end else if (kind < 60) begin
				k = $urandom_range(2, 16);
				m = ALL_ONES << k;
				r.original_low = ($urandom & m) | {30'h0, 1'($urandom_range(0, 1)), 1'b1};
				r.sizing_low = m | 32'h1;
				if ($urandom_range(0, 1) != 0)
					r.sizing_low = r.sizing_low & IO_LIMIT;
			end else if (kind < 75) begin
				k = $urandom_range(11, 31);
				m = ALL_ONES << k;
				r.opcode = OP_ROM;
				r.original_low = ($urandom & m) | {31'h0, 1'($urandom_range(0, 1))};
				r.sizing_low = m | {31'h0, 1'($urandom_range(0, 1))};
			end else if (kind < 85) begin
				r.opcode = op_t'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
					0: r.sizing_low = 32'h0;
					1: r.sizing_low = ALL_ONES;
					default: r.original_low = ALL_ONES;
				endcase
			end else begin
				r.opcode = op_t'($urandom_range(0, 1));
			end
			bars_to_send.push_back(r);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (bars_to_send.size() != 0 || in_ch.valid || predicted_decodes.size() != 0);
	endtask

	task automatic set_wide_support(bit enable);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= enable;
		@(posedge clk);
		cfg_we <= 1'b0;
		wide_support = enable;
		settings_used++;
	endtask

	// Request side: one transfer at a time, random gap between items
	always @(posedge clk or negedge arst_n) begin : drive_bars
		bar_req_t req;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.opcode <= OP_BAR;
			in_ch.original_low <= '0;
			in_ch.sizing_low <= '0;
			in_ch.original_high <= '0;
			in_ch.sizing_high <= '0;
			send_wait = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid)
				predicted_decodes.push_back(decode_bar(sent_bar, wide_support));
			if (send_wait > 0) begin
				send_wait--;
				in_ch.valid <= 1'b0;
			end else if (bars_to_send.size() > 0) begin
				req = bars_to_send.pop_front();
				sent_bar = req;
				in_ch.valid <= 1'b1;
				in_ch.opcode <= req.opcode;
				in_ch.original_low <= req.original_low;
				in_ch.sizing_low <= req.sizing_low;
				in_ch.original_high <= req.original_high;
				in_ch.sizing_high <= req.sizing_high;
				if (send_run == 0) begin
					send_run = $urandom_range(10, 60);
					send_calm = ($urandom_range(0, 2) == 0);
				end
				send_run--;
				send_wait = pick_wait(send_calm);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: check each transfer, then hold ready low for a random stall
	always @(posedge clk or negedge arst_n) begin : check_decodes
		bar_res_t got;
		bar_res_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.valid_res = out_ch.valid_res;
				got.space_io = out_ch.space_io;
				got.prefetchable = out_ch.prefetchable;
				got.wide_bar = out_ch.wide_bar;
				got.read_only_rom = out_ch.read_only_rom;
				got.rom_enabled = out_ch.rom_enabled;
				got.type_bits = out_ch.type_bits;
				got.start_address = out_ch.start_address;
				got.end_address = out_ch.end_address;
				got.uses_next_slot = out_ch.uses_next_slot;
				decodes_seen++;
				if (got.space_io) io_seen++;
				if (got.read_only_rom) rom_seen++;
				if (got.wide_bar) wide_seen++;
				if (!got.valid_res) rejected_seen++;
				if (predicted_decodes.size() == 0) begin
					mismatches++;
					if (mismatches <= PRINT_LIMIT)
						$display("%0t unexpected result: expected none, actual %h", $time, got);
				end else begin
					want = predicted_decodes.pop_front();
					compare_field("valid_res", want.valid_res, got.valid_res);
					compare_field("space_io", want.space_io, got.space_io);
					compare_field("prefetchable", want.prefetchable, got.prefetchable);
					compare_field("wide_bar", want.wide_bar, got.wide_bar);
					compare_field("read_only_rom", want.read_only_rom, got.read_only_rom);
					compare_field("rom_enabled", want.rom_enabled, got.rom_enabled);
					compare_field("type_bits", want.type_bits, got.type_bits);
					compare_field("start_address", want.start_address, got.start_address);
					compare_field("end_address", want.end_address, got.end_address);
					compare_field("uses_next_slot", want.uses_next_slot, got.uses_next_slot);
				end
				if (recv_run == 0) begin
					recv_run = $urandom_range(10, 60);
					recv_calm = ($urandom_range(0, 2) == 0);
				end
				recv_run--;
				recv_wait = pick_wait(recv_calm);
			end
			if (recv_wait > 0) begin
				out_ch.ready <= 1'b0;
				recv_wait--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("[bar_sizing_decoder_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_BAR;
		in_ch.original_low = '0;
		in_ch.sizing_low = '0;
		in_ch.original_high = '0;
		in_ch.sizing_high = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// 64-bit support on from reset
		queue_bar(OP_BAR, 32'hfe00_0000, 32'hfff0_0000, 32'h0, 32'h0);
		queue_bar(OP_BAR, ALL_ONES, 32'hffff_f000, 32'h0, 32'h0);
		queue_bar(OP_BAR, 32'h1000_0000, 32'h0, 32'h0, 32'h0);
		queue_bar(OP_BAR, 32'h1000_0000, ALL_ONES, 32'h0, 32'h0);
		queue_bar(OP_BAR, 32'h0000_e001, 32'hffff_ff01, 32'h0, 32'h0);
		queue_bar(OP_BAR, 32'h8000_0005, 32'h0000_0001, ALL_ONES, ALL_ONES);
		queue_bar(OP_BAR, 32'hd000_0008, 32'hf000_0008, 32'h0, 32'h0);
		queue_bar(OP_BAR, 32'h000f_0002, 32'hffff_0002, 32'h0, 32'h0);
		queue_bar(OP_BAR, 32'h000f_0006, 32'hffff_0006, 32'h1234_5678, 32'h0);
		queue_bar(OP_BAR, 32'h0000_000c, 32'h0000_000c, 32'h0000_0004, 32'hffff_fff0);
		queue_bar(OP_BAR, 32'he000_0004, 32'hf000_0004, 32'h0000_0001, 32'h0);
		// upper end wraps past 2^64
		queue_bar(OP_BAR, 32'hffff_fff4, 32'h0000_0010, ALL_ONES, 32'h0000_0001);
		queue_bar(OP_BAR, 32'h7fff_fff4, 32'hffff_fffe, ALL_ONES, ALL_ONES);
		queue_bar(OP_BAR, 32'h0, 32'h0000_0001, 32'h0, 32'h0);
		queue_bar(OP_ROM, 32'hfff0_0001, 32'hfffe_0001, 32'h0, 32'h0);
		queue_bar(OP_ROM, 32'h000c_0000, 32'hffff_f800, ALL_ONES, ALL_ONES);
		queue_bar(OP_ROM, 32'h000c_0001, 32'h0, 32'h0, 32'h0);
		queue_bar(OP_ROM, ALL_ONES, 32'h8000_0000, 32'h0, 32'h0);
		queue_bar(OP_ROM, 32'hffff_fffe, 32'hffff_fffe, 32'h0, 32'h0);
		wait_drained();

		set_wide_support(1'b0);
		queue_bar(OP_BAR, 32'hc000_0004, 32'hfff0_0004, 32'h0000_0002, ALL_ONES);
		queue_bar(OP_BAR, 32'hc000_000c, 32'hfff0_000c, 32'h0, ALL_ONES);
		queue_bar(OP_BAR, 32'h0000_0004, 32'h0, 32'h0000_0005, 32'h0000_0005);
		queue_random(280);
		wait_drained();

		set_wide_support(1'b1);
		queue_random(350);
		wait_drained();

		set_wide_support(1'b0);
		queue_random(250);
		wait_drained();

		set_wide_support(1'b1);
		queue_random(270);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("decoded %0d BARs: %0d I/O, %0d ROM, %0d 64-bit, %0d rejected",
			decodes_seen, io_seen, rom_seen, wide_seen, rejected_seen);
		$display("64-bit support changed across %0d settings, %0d field mismatches",
			settings_used, mismatches);
		if (mismatches == 0 && predicted_decodes.size() == 0)
			$display("[bar_sizing_decoder_unit] OK");
		else
			$display("[bar_sizing_decoder_unit] ERROR");
		$finish;
	end

endmodule

### bar_sizing_decoder_unit.f
design/bsd_pkg.sv
design/bsd_in_if.sv
design/bsd_out_if.sv
design/bsd_decode.sv
design/bar_sizing_decoder_unit.sv
design/bsd_checker.sv
dv/bar_sizing_decoder_unit_tb.sv
